// File: rtl/hss_pkg.sv
// Shared types and constants of the hidden Markov model sequence sampler.
// Holds opcodes, table selects, the controller state type and the RAM write bundle.
// No dependencies.
`timescale 1ns / 1ps

package hss_pkg;

    // Field widths
    localparam int PROB_W   = 16;
    localparam int IDX_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int LEN_W    = 16;
    localparam int SUM_W    = PROB_W + 1;

    // Table memory: three regions of 16 x 16 entries
    localparam int SEL_W      = 2;
    localparam int ADDR_W     = SEL_W + 2 * IDX_W;
    localparam int RAM_DEPTH  = 3 * (1 << (2 * IDX_W));
    localparam int TABLE_SIZE = 1 << IDX_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE_LEN   = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_INIT  = 2'd0,
        OP_LOAD_TRANS = 2'd1,
        OP_LOAD_EMIT  = 2'd2,
        OP_STEP       = 2'd3
    } opcode_t;

    typedef enum logic [SEL_W-1:0] {
        TBL_INIT  = 2'd0,
        TBL_TRANS = 2'd1,
        TBL_EMIT  = 2'd2
    } table_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STATE_WALK,
        ST_SYMBOL_WALK,
        ST_DONE
    } fsm_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PROB_W-1:0] data;
    } ram_wr_t;

endpackage

// File: rtl/hss_table_ram.sv
// Probability table memory: one write port, one read port, registered read data.
// Uses hss_pkg for widths and the write bundle.
`timescale 1ns / 1ps

module hss_table_ram
(
    input  logic                       clk,
    input  hss_pkg::ram_wr_t           wr,
    input  logic [hss_pkg::ADDR_W-1:0] rd_addr,
    output logic [hss_pkg::PROB_W-1:0] rd_data
);

    logic [hss_pkg::PROB_W-1:0] mem [0:hss_pkg::RAM_DEPTH-1];
    logic [hss_pkg::PROB_W-1:0] rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read one entry a cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/hmm_sequence_sampler.sv
// Top level of the hidden Markov model sequence sampler.
// Depends on hss_pkg and hss_table_ram.
`timescale 1ns / 1ps

// Usage:
// Input transfers on s_* carry either a table load or a step. s_tuser holds
// the opcode: load initial, load transition, load emission or step. A load
// writes one 16-bit entry of the table memory in the cycle of its transfer and
// gives no result. A step draws the hidden state from the initial vector (first
// step of a sequence) or from the transition row of the current state, then the
// symbol from the emission row of that state, and gives one result on m_*
// with m_tlast marking the last step of a sequence.
// Timing: a load leaves the block ready for the next item. A step walks its
// table rows one entry per cycle through the registered read; each draw walks
// 1 to 16 entries until it lands, and the next item is taken only once the
// step has handed on its result.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, a finished step holds until the output
// register frees, and no further item is taken meanwhile.
// Reset: current state and sequence position clear, registers go to 16
// states, 16 symbols, length 1. Table contents are undefined until loaded.
// Configuration writes on cfg_* take effect at once; the user makes them while idle, the block does not enforce it.
module hmm_sequence_sampler
(
    input  logic        clk,
    input  logic        rst_n,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: row_index[3:0], column_index[7:4], probability[23:8],
    //        random_for_state[39:24], random_for_symbol[55:40]
    input  logic [55:0] s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]  s_tuser,

    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: hidden_state[3:0], emitted_symbol[7:4]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,

    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int PW = hss_pkg::PROB_W;
    localparam int IW = hss_pkg::IDX_W;
    localparam int CW = hss_pkg::COUNT_W;
    localparam int LW = hss_pkg::LEN_W;
    localparam int SW = hss_pkg::SUM_W;

    // Input fields
    logic [IW-1:0]    in_row;
    logic [IW-1:0]    in_col;
    logic [PW-1:0]    in_prob;
    logic [PW-1:0]    in_rand_state;
    logic [PW-1:0]    in_rand_symbol;
    hss_pkg::opcode_t in_op;

    assign in_row         = s_tdata[3:0];
    assign in_col         = s_tdata[7:4];
    assign in_prob        = s_tdata[23:8];
    assign in_rand_state  = s_tdata[39:24];
    assign in_rand_symbol = s_tdata[55:40];
    assign in_op          = hss_pkg::opcode_t'(s_tuser);

    // Registers
    hss_pkg::fsm_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [PW-1:0] rs_reg, ry_reg;
    logic [IW-1:0] st_reg, st_next;
    logic [IW-1:0] sy_reg, sy_next;
    logic [IW-1:0] cur_state_reg, cur_state_next;
    logic [LW-1:0] step_pos_reg, step_pos_next;
    logic [CW-1:0] states_in_use_reg;
    logic [CW-1:0] symbols_in_use_reg;
    logic [LW-1:0] seq_len_reg;
    logic          out_valid_reg, out_valid_next;
    logic [IW-1:0] out_state_reg;
    logic [IW-1:0] out_symbol_reg;
    logic          out_last_reg;

    // Datapath signals
    logic                       in_accept;
    logic                       step_accept;
    hss_pkg::ram_wr_t           ram_wr;
    logic [hss_pkg::ADDR_W-1:0] rd_addr;
    logic [PW-1:0]              rd_data;
    logic [IW-1:0]              ns_last;
    logic [IW-1:0]              ny_last;
    logic [IW-1:0]              walk_last;
    logic [PW-1:0]              walk_rand;
    logic [SW-1:0]              sum_add;
    logic                       hit;
    logic [LW-1:0]              len_eff;
    logic                       last_step;
    logic                       out_free;
    logic                       out_load;
    hss_pkg::table_sel_t        rd_sel;
    logic [IW-1:0]              rd_row;

    assign s_tready    = (state_reg == hss_pkg::ST_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign step_accept = in_accept && (in_op == hss_pkg::OP_STEP);

    // Clamp counts to 1..16, expressed as last index in use
    always_comb
    begin
        if (states_in_use_reg == '0)
            ns_last = '0;
        else if (states_in_use_reg > CW'(hss_pkg::TABLE_SIZE))
            ns_last = IW'(hss_pkg::TABLE_SIZE - 1);
        else
            ns_last = IW'(states_in_use_reg - CW'(1));

        if (symbols_in_use_reg == '0)
            ny_last = '0;
        else if (symbols_in_use_reg > CW'(hss_pkg::TABLE_SIZE))
            ny_last = IW'(hss_pkg::TABLE_SIZE - 1);
        else
            ny_last = IW'(symbols_in_use_reg - CW'(1));
    end

    // Sequence end test
    assign len_eff   = (seq_len_reg == '0) ? LW'(1) : seq_len_reg;
    assign last_step = ({1'b0, step_pos_reg} + (LW+1)'(1)) >= {1'b0, len_eff};

    // Table load write
    always_comb
    begin
        ram_wr.en   = in_accept && (in_op != hss_pkg::OP_STEP);
        ram_wr.data = in_prob;
        unique case (in_op)
            hss_pkg::OP_LOAD_INIT:  ram_wr.addr = {hss_pkg::TBL_INIT, IW'(0), in_col};
            hss_pkg::OP_LOAD_TRANS: ram_wr.addr = {hss_pkg::TBL_TRANS, in_row, in_col};
            hss_pkg::OP_LOAD_EMIT:  ram_wr.addr = {hss_pkg::TBL_EMIT, in_row, in_col};
            hss_pkg::OP_STEP:       ram_wr.addr = {hss_pkg::TBL_EMIT, in_row, in_col};
        endcase
    end

    // Walk read address: region, row, running index
    always_comb
    begin
        if (state_reg == hss_pkg::ST_SYMBOL_WALK)
        begin
            rd_sel    = hss_pkg::TBL_EMIT;
            rd_row    = st_reg;
            walk_last = ny_last;
            walk_rand = ry_reg;
        end
        else if (step_pos_reg == '0)
        begin
            rd_sel    = hss_pkg::TBL_INIT;
            rd_row    = '0;
            walk_last = ns_last;
            walk_rand = rs_reg;
        end
        else
        begin
            rd_sel    = hss_pkg::TBL_TRANS;
            rd_row    = cur_state_reg;
            walk_last = ns_last;
            walk_rand = rs_reg;
        end
    end

    assign rd_addr = {rd_sel, rd_row, idx_reg};

    hss_table_ram u_table_ram
    (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Running sum and draw decision on the returning entry
    assign sum_add = sum_reg + {1'b0, rd_data};
    assign hit     = rd_valid_reg
                     && ((sum_add > {1'b0, walk_rand}) || (rd_idx_reg == walk_last));

    assign out_free = !out_valid_reg || m_tready;

    // Next state and walk control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = idx_reg;
        st_next        = st_reg;
        sy_next        = sy_reg;
        cur_state_next = cur_state_reg;
        step_pos_next  = step_pos_reg;
        out_load       = 1'b0;

        unique case (state_reg)
            hss_pkg::ST_IDLE:
            begin
                if (step_accept)
                begin
                    state_next = hss_pkg::ST_STATE_WALK;
                    idx_next   = '0;
                    sum_next   = '0;
                end
            end

            hss_pkg::ST_STATE_WALK,
            hss_pkg::ST_SYMBOL_WALK:
            begin
                // Issue a read every cycle until the draw hits, hold the index at the last entry
                rd_valid_next = !hit;
                idx_next      = (idx_reg == walk_last) ? idx_reg : idx_reg + IW'(1);
                if (rd_valid_reg)
                    sum_next = sum_add;
                if (hit)
                begin
                    idx_next = '0;
                    sum_next = '0;
                    if (state_reg == hss_pkg::ST_STATE_WALK)
                    begin
                        st_next    = rd_idx_reg;
                        state_next = hss_pkg::ST_SYMBOL_WALK;
                    end
                    else
                    begin
                        sy_next    = rd_idx_reg;
                        state_next = hss_pkg::ST_DONE;
                    end
                end
            end

            hss_pkg::ST_DONE:
            begin
                // Hand the result over once the output register is free
                if (out_free)
                begin
                    out_load       = 1'b1;
                    cur_state_next = st_reg;
                    step_pos_next  = last_step ? '0 : step_pos_reg + LW'(1);
                    state_next     = hss_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hss_pkg::ST_IDLE;
            idx_reg       <= '0;
            sum_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            cur_state_reg <= '0;
            step_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            rd_valid_reg  <= rd_valid_next;
            rd_idx_reg    <= rd_idx_next;
            cur_state_reg <= cur_state_next;
            step_pos_reg  <= step_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_in_use_reg  <= CW'(hss_pkg::TABLE_SIZE);
            symbols_in_use_reg <= CW'(hss_pkg::TABLE_SIZE);
            seq_len_reg        <= LW'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hss_pkg::CFG_STATES_IN_USE:  states_in_use_reg  <= cfg_wdata[CW-1:0];
                hss_pkg::CFG_SYMBOLS_IN_USE: symbols_in_use_reg <= cfg_wdata[CW-1:0];
                hss_pkg::CFG_SEQUENCE_LEN:   seq_len_reg        <= cfg_wdata[LW-1:0];
                default:                     ;
            endcase
        end
    end

    // Payload registers: random values, drawn indexes, output
    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            rs_reg <= in_rand_state;
            ry_reg <= in_rand_symbol;
        end
        st_reg <= st_next;
        sy_reg <= sy_next;
        if (out_load)
        begin
            out_state_reg  <= st_reg;
            out_symbol_reg <= sy_reg;
            out_last_reg   <= last_step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_symbol_reg, out_state_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // Entry reads only return while a row is being walked
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == hss_pkg::ST_STATE_WALK
                          || state_reg == hss_pkg::ST_SYMBOL_WALK))
        else $error("table read data returned outside a walk");

    // The state walk index never runs past the last state in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hss_pkg::ST_STATE_WALK) |-> (idx_reg <= ns_last))
        else $error("state walk index beyond states in use");

    // A step that ends the sequence restarts the position and shows m_tlast
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_step) |=> (step_pos_reg == '0 && m_tvalid && m_tlast))
        else $error("sequence end did not restart the step position");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the hidden Markov model sequence sampler.
// Depends on hss_pkg and the hmm_sequence_sampler RTL; a scoreboard class predicts each draw.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF        = 4;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_ITEMS     = 130;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One input transfer, split into its fields
    typedef struct packed {
        hss_pkg::opcode_t op;
        logic [3:0]       row;
        logic [3:0]       col;
        logic [15:0]      prob;
        logic [15:0]      rnd_state;
        logic [15:0]      rnd_symbol;
    } hmm_item_t;

    // One drawn step
    typedef struct packed {
        logic [3:0] state;
        logic [3:0] symbol;
        logic       last;
    } hmm_draw_t;

    // Predicts the sampler and checks its output transfers in order
    class hmm_scoreboard;
        logic [15:0] init_tbl  [16];
        logic [15:0] trans_tbl [16][16];
        logic [15:0] emit_tbl  [16][16];
        logic [3:0]  cur_state;
        logic [15:0] position;
        logic [4:0]  n_states;
        logic [4:0]  n_symbols;
        logic [15:0] seq_len;
        hmm_draw_t   draws_due [$];
        int          errors;

        function new();
            cur_state = '0;
            position  = '0;
            n_states  = 5'd16;
            n_symbols = 5'd16;
            seq_len   = 16'd1;
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                hss_pkg::CFG_STATES_IN_USE:  n_states  = value[4:0];
                hss_pkg::CFG_SYMBOLS_IN_USE: n_symbols = value[4:0];
                hss_pkg::CFG_SEQUENCE_LEN:   seq_len   = value;
                default: ;
            endcase
        endfunction

        function int clamp_count(logic [4:0] v);
            if (v == 0)
                return 1;
            if (v > hss_pkg::TABLE_SIZE)
                return hss_pkg::TABLE_SIZE;
            return v;
        endfunction

        // Walk one row; first index whose running sum passes rnd, else the last
        function int draw_index(hss_pkg::table_sel_t sel, int row, int count,
                                logic [15:0] rnd);
            logic [hss_pkg::SUM_W-1:0] sum;
            int i;
            sum = '0;
            for (i = 0; i < count; i++)
            begin
                case (sel)
                    hss_pkg::TBL_INIT:  sum += init_tbl[i];
                    hss_pkg::TBL_TRANS: sum += trans_tbl[row][i];
                    default:            sum += emit_tbl[row][i];
                endcase
                if (sum > rnd)
                    return i;
            end
            return count - 1;
        endfunction

        function void note_item(hmm_item_t it);
            hmm_draw_t d;
            int ns;
            int ny;
            int len;
            int st;
            case (it.op)
                hss_pkg::OP_LOAD_INIT:  init_tbl[it.col] = it.prob;
                hss_pkg::OP_LOAD_TRANS: trans_tbl[it.row][it.col] = it.prob;
                hss_pkg::OP_LOAD_EMIT:  emit_tbl[it.row][it.col] = it.prob;
                default:
                begin
                    ns  = clamp_count(n_states);
                    ny  = clamp_count(n_symbols);
                    len = (seq_len == 0) ? 1 : int'(seq_len);
                    if (position == 0)
                        st = draw_index(hss_pkg::TBL_INIT, 0, ns, it.rnd_state);
                    else
                        st = draw_index(hss_pkg::TBL_TRANS, cur_state, ns, it.rnd_state);
                    d.state  = st[3:0];
                    d.symbol = 4'(draw_index(hss_pkg::TBL_EMIT, st, ny, it.rnd_symbol));
                    d.last   = (int'(position) + 1 >= len);
                    cur_state = d.state;
                    position  = d.last ? 16'd0 : position + 16'd1;
                    draws_due.push_back(d);
                end
            endcase
        endfunction

        function void check_result(logic [7:0] data, logic last);
            hmm_draw_t d;
            if (draws_due.size() == 0)
            begin
                $display("%0t: unexpected result state %0d symbol %0d last %0b",
                         $time, data[3:0], data[7:4], last);
                errors++;
                return;
            end
            d = draws_due.pop_front();
            if (data[3:0] !== d.state)
            begin
                $display("%0t: hidden_state expected %0d actual %0d", $time, d.state, data[3:0]);
                errors++;
            end
            if (data[7:4] !== d.symbol)
            begin
                $display("%0t: emitted_symbol expected %0d actual %0d",
                         $time, d.symbol, data[7:4]);
                errors++;
            end
            if (last !== d.last)
            begin
                $display("%0t: last_of_sequence expected %0b actual %0b", $time, d.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return draws_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    hmm_scoreboard sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    logic          hold_off;
    int            cycle_count;

    hmm_sequence_sampler uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Accept results, check them, and pick the ready level for the next cycle
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic hmm_item_t make_item(hss_pkg::opcode_t op, logic [3:0] row,
                                            logic [3:0] col, logic [15:0] prob,
                                            logic [15:0] rs, logic [15:0] ry);
        hmm_item_t it;
        it.op         = op;
        it.row        = row;
        it.col        = col;
        it.prob       = prob;
        it.rnd_state  = rs;
        it.rnd_symbol = ry;
        return it;
    endfunction

    // Random fraction biased toward the ends and toward small values
    function automatic logic [15:0] random_fraction();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 4095));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic hmm_item_t random_item();
        hmm_item_t it;
        if ($urandom_range(0, 99) < 65)
            it.op = hss_pkg::OP_STEP;
        else
            it.op = hss_pkg::opcode_t'($urandom_range(0, 2));
        it.row = 4'($urandom());
        it.col = 4'($urandom());
        // Mostly small entries so that walks run deep into a row
        case ($urandom_range(0, 7))
            0:       it.prob = 16'h0000;
            1:       it.prob = 16'hFFFF;
            2, 3:    it.prob = 16'($urandom());
            default: it.prob = 16'($urandom_range(0, 8191));
        endcase
        it.rnd_state  = random_fraction();
        it.rnd_symbol = random_fraction();
        return it;
    endfunction

    task automatic set_idle(idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER)   ? 84 : (mode == IDLE_BOTH) ? 29 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 84 : (mode == IDLE_BOTH) ? 29 : 0;
    endtask

    // Offer one item, with optional idle cycles first, and hold it until the transfer
    task automatic send_item(hmm_item_t it);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.rnd_symbol, it.rnd_state, it.prob, it.col, it.row};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(it);
    endtask

    // Drop valid, wait for every result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_config(int states, int symbols, int len);
        logic [1:0]  regs [3];
        logic [15:0] vals [3];
        int i;
        regs[0] = hss_pkg::CFG_STATES_IN_USE;
        regs[1] = hss_pkg::CFG_SYMBOLS_IN_USE;
        regs[2] = hss_pkg::CFG_SEQUENCE_LEN;
        vals[0] = 16'(states);
        vals[1] = 16'(symbols);
        vals[2] = 16'(len);
        for (i = 0; i < 3; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.write_reg(regs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int          p;
        int          n;
        int          r;
        int          c;
        int          phase_states  [PHASE_COUNT];
        int          phase_symbols [PHASE_COUNT];
        int          phase_len     [PHASE_COUNT];
        idle_mode_t  phase_mode    [PHASE_COUNT];

        sb = new();
        hold_off <= 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= hss_pkg::OP_LOAD_INIT;
        cfg_wr_en <= 1'b0;
        cfg_index <= hss_pkg::CFG_STATES_IN_USE;
        cfg_wdata <= '0;
        set_idle(IDLE_NONE);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every table entry so that no draw reads an unwritten one
        for (c = 0; c < 16; c++)
            send_item(make_item(hss_pkg::OP_LOAD_INIT, 4'($urandom()), 4'(c),
                                16'($urandom_range(0, 8191)), 16'($urandom()), 16'($urandom())));
        for (r = 0; r < 16; r++)
            for (c = 0; c < 16; c++)
            begin
                send_item(make_item(hss_pkg::OP_LOAD_TRANS, 4'(r), 4'(c),
                                    16'($urandom_range(0, 8191)), 16'($urandom()),
                                    16'($urandom())));
                send_item(make_item(hss_pkg::OP_LOAD_EMIT, 4'(r), 4'(c),
                                    16'($urandom_range(0, 8191)), 16'($urandom()),
                                    16'($urandom())));
            end
        drain();

        // Directed: two states, two symbols, sequences of three
        program_config(2, 2, 3);
        send_item(make_item(hss_pkg::OP_LOAD_INIT,  4'hF, 4'h0, 16'h8000, 16'hFFFF, 16'hFFFF));
        send_item(make_item(hss_pkg::OP_LOAD_INIT,  4'h0, 4'h1, 16'h8000, 16'h0000, 16'h0000));
        send_item(make_item(hss_pkg::OP_LOAD_TRANS, 4'h0, 4'h0, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(hss_pkg::OP_LOAD_TRANS, 4'h0, 4'h1, 16'hFFFF, 16'h0000, 16'h0000));
        send_item(make_item(hss_pkg::OP_LOAD_TRANS, 4'h1, 4'h0, 16'hFFFF, 16'h0000, 16'h0000));
        send_item(make_item(hss_pkg::OP_LOAD_TRANS, 4'hF, 4'hF, 16'h0000, 16'hFFFF, 16'hFFFF));
        send_item(make_item(hss_pkg::OP_LOAD_EMIT,  4'h0, 4'h0, 16'hFFFF, 16'h0000, 16'h0000));
        send_item(make_item(hss_pkg::OP_LOAD_EMIT,  4'h1, 4'h0, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(hss_pkg::OP_LOAD_EMIT,  4'h1, 4'h1, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(hss_pkg::OP_LOAD_EMIT,  4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Exact boundary, fallback on an all-zero row, and start of a new sequence
        send_item(make_item(hss_pkg::OP_STEP, 4'h0, 4'h0, 16'h0000, 16'h7FFF, 16'h0000));
        send_item(make_item(hss_pkg::OP_STEP, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(hss_pkg::OP_STEP, 4'h0, 4'h0, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(hss_pkg::OP_STEP, 4'h0, 4'h0, 16'h0000, 16'h8000, 16'h1234));
        send_item(make_item(hss_pkg::OP_STEP, 4'h0, 4'h0, 16'h0000, 16'h0000, 16'hFFFF));
        send_item(make_item(hss_pkg::OP_STEP, 4'h0, 4'h0, 16'h0000, 16'hFFFF, 16'h0000));
        drain();
        // Zero in every count register acts as one
        program_config(0, 0, 0);
        send_item(make_item(hss_pkg::OP_STEP, 4'h0, 4'h0, 16'h0000, 16'hFFFF, 16'hFFFF));
        send_item(make_item(hss_pkg::OP_STEP, 4'h0, 4'h0, 16'h0000, 16'h0000, 16'h0000));
        drain();

        // Random phases: settings and idling differ per phase
        phase_states  = '{16, 4, 1, 31, 0, 16, 0, 16};
        phase_symbols = '{16, 5, 16, 0, 17, 1, 0, 16};
        phase_len     = '{1, 7, 65535, 2, 0, 16, 0, 5};
        phase_mode    = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                          IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        phase_states[6]  = $urandom_range(0, 31);
        phase_symbols[6] = $urandom_range(0, 31);
        phase_len[6]     = $urandom_range(0, 9);
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            program_config(phase_states[p], phase_symbols[p], phase_len[p]);
            set_idle(phase_mode[p]);
            // Hold the receiver off for a long stretch so the input backs up
            if (p == 0)
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_OFF_CYCLES) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item());
            drain();
        end

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/hss_pkg.sv
rtl/hss_table_ram.sv
rtl/hmm_sequence_sampler.sv
verif/tb_top.sv
